FILE: design/bin_presence_sort_core_defines.svh
// Assertion macros shared by the bin presence sort RTL.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef BIN_PRESENCE_SORT_CORE_DEFINES_SVH
`define BIN_PRESENCE_SORT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define BPS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BPS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/bps_pkg.sv
// Package for the bin presence sort: sizes, limits and the cell control struct.
// No dependencies.
package bps_pkg;

  localparam int KEY_RANGE = 64;                  // number of bins, 2..64
  localparam int MAX_ITEMS = 64;                  // keys per set, 1..127
  localparam int KEY_W     = 6;                   // key field width
  localparam int CNT_W     = 7;                   // item counter width
  localparam int SCAN_W    = $clog2(KEY_RANGE);   // scan position width

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic             load;   // a key transaction is being taken
    logic             shift;  // scan step: every flag moves one cell down
    logic             clear;  // drop all flags
    logic [KEY_W-1:0] key;
  } cell_ctl_t;

endpackage

FILE: design/bps_in_if.sv
// Input channel of the bin presence sort: one key per transaction.
// Depends on bps_pkg.
interface bps_in_if;
  import bps_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key;
  logic             last_key;

  modport source (output valid, key, last_key, input ready);
  modport sink   (input valid, key, last_key, output ready);
endinterface

FILE: design/bps_out_if.sv
// Output channel of the bin presence sort: one sorted key per transaction.
// Depends on bps_pkg.
interface bps_out_if;
  import bps_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] sorted_value;
  logic             final_value;
  logic             too_many;

  modport source (output valid, sorted_value, final_value, too_many, input ready);
  modport sink   (input valid, sorted_value, final_value, too_many, output ready);
endinterface

FILE: design/bps_cell.sv
// One bin of the sort chain: a presence flag that is set by a matching key
// and shifted toward cell 0 during the scan. Depends on bps_pkg.
module bps_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bps_pkg::cell_ctl_t      ctl_i,
  input  logic [bps_pkg::KEY_W-1:0] bin_idx_i,
  input  logic                    shift_in_i,
  output logic                    flag_o
);
  import bps_pkg::*;

  logic flag_d, flag_q;

  always_comb begin
    flag_d = flag_q;
    if (ctl_i.clear) begin
      flag_d = 1'b0;
    end else if (ctl_i.shift) begin
      flag_d = shift_in_i;
    end else if (ctl_i.load && (ctl_i.key == bin_idx_i)) begin
      flag_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else begin
      flag_q <= flag_d;
    end
  end

  assign flag_o = flag_q;
endmodule

FILE: design/bin_presence_sort_core.sv
// Bin presence sort core: top level with the cell chain and the sequencer.
// Depends on bps_pkg, bps_in_if, bps_out_if, bps_cell and the assertion macros.
//
// Keys arrive one per input transaction; each sets the presence flag of its
// bin (keys at or above KEY_RANGE set nothing but still count) and the item
// counter goes up, saturating at MAX_ITEMS with a sticky overflow bit. Loading
// takes one key per cycle. The transaction with last_key high closes the set
// and starts the output phase, during which in_i.ready stays low:
//  - normal set: the row of KEY_RANGE cells shifts its flags down by one bin
//    per cycle, and cell 0 is inspected against a scan counter. A found key is
//    held in a pending register until the next is found, so the last one
//    can be marked final_value. The scan covers all KEY_RANGE bins, then
//    flushes; stalls on out_o pause it. Zeros shifted in leave every bin
//    clear at the end. A set with no bin flagged gives no output transaction.
//  - more than MAX_ITEMS keys: a single transaction with too_many and
//    final_value high and sorted_value zero, and all bins cleared.
// The result sits in an output register, so the last result of a set may
// still be waiting while keys of the next set are being taken. All state is
// in flip-flops cleared by reset; there is no clearing pass.
module bin_presence_sort_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  bps_in_if.sink    in_i,
  bps_out_if.source out_o
);
  import bps_pkg::*;
  `include "bin_presence_sort_core_defines.svh"

  typedef enum logic [1:0] {
    S_LOAD,
    S_SCAN,
    S_FLUSH,
    S_ERR
  } state_e;

  localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(KEY_RANGE - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_ITEMS);

  state_e             state_d, state_q;
  logic [CNT_W-1:0]   count_d, count_q;
  logic               over_d, over_q;
  logic [SCAN_W-1:0]  idx_d, idx_q;
  logic               pend_valid_d, pend_valid_q;
  logic [KEY_W-1:0]   pend_key_d, pend_key_q;
  logic               out_valid_d, out_valid_q;
  logic [KEY_W-1:0]   out_value_d, out_value_q;
  logic               out_final_d, out_final_q;
  logic               out_err_d, out_err_q;

  logic                 in_fire;
  logic                 out_free;
  logic                 ovf_now;
  cell_ctl_t            ctl;
  logic [KEY_RANGE-1:0] flags;

  // ---------------------------------------------------------------------------
  // Cell chain: cell g holds bin g while loading; during the scan the flags
  // move one cell toward cell 0 each step.
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < KEY_RANGE; g++) begin : g_cell
    logic shift_in;
    if (g == KEY_RANGE - 1) begin : g_tail
      assign shift_in = 1'b0;
    end else begin : g_body
      assign shift_in = flags[g+1];
    end
    bps_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .bin_idx_i  (KEY_W'(g)),
      .shift_in_i (shift_in),
      .flag_o     (flags[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign in_i.ready = (state_q == S_LOAD);
  assign in_fire    = in_i.valid && (state_q == S_LOAD);
  assign out_free   = !out_valid_q || out_o.ready;
  // overflow including the key being taken now
  assign ovf_now    = over_q || (count_q == CNT_MAX);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    over_d       = over_q;
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    pend_key_d   = pend_key_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_value_d  = out_value_q;
    out_final_d  = out_final_q;
    out_err_d    = out_err_q;

    ctl.load  = in_fire;
    ctl.shift = 1'b0;
    ctl.clear = 1'b0;
    ctl.key   = in_i.key;

    case (state_q)
      S_LOAD: begin
        if (in_fire) begin
          if (ovf_now) begin
            over_d = 1'b1;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
          if (in_i.last_key) begin
            count_d = '0;
            over_d  = 1'b0;
            idx_d   = '0;
            state_d = ovf_now ? S_ERR : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (out_free) begin
          ctl.shift = 1'b1;
          if (flags[0]) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_value_d = pend_key_q;
              out_final_d = 1'b0;
              out_err_d   = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_key_d   = KEY_W'(idx_q);
          end
          idx_d = idx_q + SCAN_W'(1);
          if (idx_q == SCAN_LAST) begin
            state_d = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = S_LOAD;   // empty set: nothing to send
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = pend_key_q;
          out_final_d  = 1'b1;
          out_err_d    = 1'b0;
          pend_valid_d = 1'b0;
          state_d      = S_LOAD;
        end
      end
      S_ERR: begin
        if (out_free) begin
          ctl.clear   = 1'b1;
          out_valid_d = 1'b1;
          out_value_d = '0;
          out_final_d = 1'b1;
          out_err_d   = 1'b1;
          state_d     = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      count_q      <= '0;
      over_q       <= 1'b0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      pend_key_q   <= '0;
      out_valid_q  <= 1'b0;
      out_value_q  <= '0;
      out_final_q  <= 1'b0;
      out_err_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      over_q       <= over_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      pend_key_q   <= pend_key_d;
      out_valid_q  <= out_valid_d;
      out_value_q  <= out_value_d;
      out_final_q  <= out_final_d;
      out_err_q    <= out_err_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.sorted_value = out_value_q;
  assign out_o.final_value  = out_final_q;
  assign out_o.too_many     = out_err_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `BPS_ASSERT_IMP(a_count_cap, 1'b1, count_q <= CNT_MAX, "item count above limit")
  `BPS_ASSERT_IMP(a_err_shape, out_o.valid && out_o.too_many,
                  out_o.final_value && (out_o.sorted_value == '0), "malformed error result")
  `BPS_ASSERT_IMP(a_pend_phase, pend_valid_q, (state_q == S_SCAN) || (state_q == S_FLUSH),
                  "pending key outside the scan")
  `BPS_ASSERT_IMP(a_bins_clear, (state_q == S_LOAD) && ($past(state_q) != S_LOAD),
                  flags == '0, "bins not clear after a set")
endmodule

FILE: sim/tb_bin_presence_sort_core.sv
`timescale 1ns / 1ps
// Self-checking bench for bin_presence_sort_core: directed table then random key sets.
// Depends on bps_pkg, bps_in_if, bps_out_if and the core RTL.
module tb_bin_presence_sort_core;
  import bps_pkg::*;

  localparam int RAND_ITEMS   = 180;
  localparam int LIMIT_CYCLES = 600000;
  localparam int DIR_N        = 18;

  typedef struct packed {
    logic [KEY_W-1:0] value;
    logic             fin;
    logic             over;
  } sorted_t;

  // One directed row: key repeated reps times, last_key on the final repeat if last is set.
  // lit marks rows whose single result is typed in below.
  typedef struct {
    logic [KEY_W-1:0] key;
    bit               last;
    int unsigned      reps;
    bit               lit;
    sorted_t          want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  bps_in_if  in_if ();
  bps_out_if out_if ();

  bin_presence_sort_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predictor state: presence bins, saturating tally, sticky overflow.
  logic [KEY_RANGE-1:0] bin_seen   = '0;
  logic [CNT_W-1:0]     key_tally  = '0;
  logic                 tally_over = 1'b0;
  sorted_t              sorted_q[$];

  dir_row_t dir_tab [DIR_N];

  int  err_cnt   = 0;
  int  cycle_cnt = 0;
  int  n_sets    = 0;
  int  n_over    = 0;
  int  n_results = 0;
  int  n_keys    = 0;
  bit  quiet     = 1'b0;
  sorted_t want;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    wait (cycle_cnt >= LIMIT_CYCLES);
    $display("%0t: timeout, %0d results still expected", $time, sorted_q.size());
    $display("tb_bin_presence_sort_core: errors");
    $finish;
  end

  // Alternate stretches with and without idling on both sides.
  initial begin
    forever begin
      repeat ($urandom_range(50, 300)) @(posedge clk_i);
      quiet = ($urandom_range(0, 99) < 30);
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 70) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Predictor: take one key; on last_key, produce the run of results.
  task automatic absorb_key(input logic [KEY_W-1:0] k, input bit lst, input bit emit);
    int      b;
    int      top;
    sorted_t r;
    if (int'(k) < KEY_RANGE) bin_seen[k] = 1'b1;
    if (key_tally >= CNT_W'(MAX_ITEMS)) tally_over = 1'b1;
    else key_tally = key_tally + 1'b1;
    if (!lst) return;
    n_sets++;
    if (tally_over) begin
      n_over++;
      r.value = '0;
      r.fin   = 1'b1;
      r.over  = 1'b1;
      if (emit) sorted_q.push_back(r);
    end else begin
      // empty run gives nothing: top stays -1
      top = -1;
      for (b = 0; b < KEY_RANGE; b++) if (bin_seen[b]) top = b;
      for (b = 0; b <= top; b++) begin
        if (bin_seen[b] && emit) begin
          r.value = KEY_W'(b);
          r.fin   = (b == top);
          r.over  = 1'b0;
          sorted_q.push_back(r);
        end
      end
    end
    bin_seen   = '0;
    key_tally  = '0;
    tally_over = 1'b0;
  endtask

  // Drive one key transaction; returns right after the accepting edge.
  task automatic send_key(input logic [KEY_W-1:0] k, input bit lst);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.key      <= k;
    in_if.last_key <= lst;
    do @(posedge clk_i); while (!in_if.ready);
    n_keys++;
  endtask

  // Output side: random back-pressure.
  initial begin
    int hold;
    hold = 0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  // Scoreboard: every output transaction against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_results++;
      if (sorted_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result value=%0d final=%0b too_many=%0b", $time,
                 out_if.sorted_value, out_if.final_value, out_if.too_many);
      end else begin
        want = sorted_q.pop_front();
        if (out_if.sorted_value !== want.value) begin
          err_cnt++;
          $display("%0t: sorted_value expected %0d got %0d", $time, want.value,
                   out_if.sorted_value);
        end
        if (out_if.final_value !== want.fin) begin
          err_cnt++;
          $display("%0t: final_value expected %0b got %0b", $time, want.fin,
                   out_if.final_value);
        end
        if (out_if.too_many !== want.over) begin
          err_cnt++;
          $display("%0t: too_many expected %0b got %0b", $time, want.over,
                   out_if.too_many);
        end
      end
    end
  end

  initial begin
    int          i;
    int unsigned r;
    int          set_len;
    int          mode;
    int          roll;
    int          band;
    int          rand_keys;
    bit          lst;
    logic [KEY_W-1:0] k;

    rst_ni         <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.key      <= '0;
    in_if.last_key <= 1'b0;

    // every bin maps to a legal key here, so neither out-of-range keys nor
    // an empty run can occur with this package
    dir_tab[0]  = '{6'd0,  1'b1, 1,  1'b1, '{6'd0,  1'b1, 1'b0}}; // lowest key alone
    dir_tab[1]  = '{6'd63, 1'b1, 1,  1'b1, '{6'd63, 1'b1, 1'b0}}; // highest key alone
    dir_tab[2]  = '{6'd7,  1'b0, 2,  1'b0, '0};                    // duplicates collapse
    dir_tab[3]  = '{6'd7,  1'b1, 1,  1'b1, '{6'd7,  1'b1, 1'b0}};
    dir_tab[4]  = '{6'd63, 1'b0, 1,  1'b0, '0};                    // out-of-order mix
    dir_tab[5]  = '{6'd0,  1'b0, 1,  1'b0, '0};
    dir_tab[6]  = '{6'd31, 1'b0, 1,  1'b0, '0};
    dir_tab[7]  = '{6'd32, 1'b0, 1,  1'b0, '0};
    dir_tab[8]  = '{6'd1,  1'b1, 1,  1'b0, '0};
    dir_tab[9]  = '{6'd42, 1'b0, 1,  1'b0, '0};                    // alternating bits
    dir_tab[10] = '{6'd21, 1'b1, 1,  1'b0, '0};
    dir_tab[11] = '{6'd10, 1'b0, MAX_ITEMS, 1'b0, '0};             // one key too many
    dir_tab[12] = '{6'd20, 1'b1, 1,  1'b1, '{6'd0,  1'b1, 1'b1}};
    dir_tab[13] = '{6'd3,  1'b0, MAX_ITEMS - 1, 1'b0, '0};         // exactly at the limit
    dir_tab[14] = '{6'd4,  1'b1, 1,  1'b0, '0};
    dir_tab[15] = '{6'd63, 1'b0, MAX_ITEMS + 6, 1'b0, '0};         // tally saturates
    dir_tab[16] = '{6'd0,  1'b1, 1,  1'b1, '{6'd0,  1'b1, 1'b1}};
    dir_tab[17] = '{6'd5,  1'b1, 1,  1'b1, '{6'd5,  1'b1, 1'b0}}; // clean after error

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DIR_N; i++) begin
      for (r = 0; r < dir_tab[i].reps; r++) begin
        lst = dir_tab[i].last && (r == dir_tab[i].reps - 1);
        send_key(dir_tab[i].key, lst);
        absorb_key(dir_tab[i].key, lst, !dir_tab[i].lit);
        if (lst && dir_tab[i].lit) sorted_q.push_back(dir_tab[i].want);
      end
    end

    // Random key sets: mostly short, some around the item limit.
    rand_keys = 0;
    while (rand_keys < RAND_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 70)      set_len = $urandom_range(1, 12);
      else if (roll < 85) set_len = $urandom_range(MAX_ITEMS - 2, MAX_ITEMS + 3);
      else                set_len = $urandom_range(13, 40);
      mode = $urandom_range(0, 2);
      band = $urandom_range(0, KEY_RANGE - 4);
      for (i = 0; i < set_len; i++) begin
        case (mode)
          0: k = KEY_W'($urandom_range(0, KEY_RANGE - 1));
          1: k = KEY_W'(band + $urandom_range(0, 3));        // heavy duplicates
          default: k = $urandom_range(0, 1) ? KEY_W'(KEY_RANGE - 1) : '0;
        endcase
        lst = (i == set_len - 1);
        send_key(k, lst);
        absorb_key(k, lst, 1'b1);
        rand_keys++;
      end
    end
    in_if.valid <= 1'b0;

    while (sorted_q.size() != 0) @(posedge clk_i);
    // a full scan plus flush must pass without stray output
    repeat (KEY_RANGE + 16) @(posedge clk_i);
    if (sorted_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d results never arrived", $time, sorted_q.size());
    end

    $display("Ran %0d key sets (%0d over the item limit) from %0d keys,", n_sets, n_over,
             n_keys);
    $display("checking %0d sorted outputs, %0d mismatches.", n_results, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_bin_presence_sort_core: clean");
    end else begin
      $display("tb_bin_presence_sort_core: errors");
    end
    $finish;
  end

endmodule

FILE: bin_presence_sort_core.f
+incdir+design
design/bps_pkg.sv
design/bps_in_if.sv
design/bps_out_if.sv
design/bps_cell.sv
design/bin_presence_sort_core.sv
sim/tb_bin_presence_sort_core.sv
